[hw/rtl/lfsw_pkg.sv]
`default_nettype none
package lfsw_pkg;

    localparam int GAIN_W = 7;
    localparam int WORD_W = 16;
    localparam logic [2:0] MAC_STEPS = 3'd7;

    localparam logic [2:0] CFG_STEER_KP = 3'd0;
    localparam logic [2:0] CFG_STEER_KI = 3'd1;
    localparam logic [2:0] CFG_STEER_KD = 3'd2;
    localparam logic [2:0] CFG_WHEEL_KP = 3'd3;
    localparam logic [2:0] CFG_WHEEL_KI = 3'd4;
    localparam logic [2:0] CFG_WHEEL_KD = 3'd5;
    localparam logic [2:0] CFG_CRUISE   = 3'd6;
    localparam logic [2:0] CFG_FINISH   = 3'd7;

    localparam logic [2:0] STAGE_RUN    = 3'd0;
    localparam logic [2:0] STAGE_COAST  = 3'd1;
    localparam logic [2:0] STAGE_HALT   = 3'd2;
    localparam logic [2:0] STAGE_SETTLE = 3'd3;
    localparam logic [2:0] STAGE_DONE   = 3'd4;

    localparam logic [1:0] TERM_P    = 2'd0;
    localparam logic [1:0] TERM_I    = 2'd1;
    localparam logic [1:0] TERM_D    = 2'd2;

    localparam logic [15:0] COAST_MS  = 16'd5000;
    localparam logic [15:0] HALT_MS   = 16'd700;
    localparam logic [15:0] SETTLE_MS = 16'd1000;
    localparam logic [4:0]  DUTY_CENTRE = 5'd18;
    localparam logic signed [15:0] DRIVE_MAX = 16'sd255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC_GO,
        ST_MAC_WAIT,
        ST_STEER_END,
        ST_WHEEL_PREP,
        ST_WHEEL_END,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                     start;
        logic                     clr;
        logic signed [WORD_W-1:0] x;
        logic [GAIN_W-1:0]        gain;
    } t_mac_req;

    typedef struct packed {
        logic                     busy;
        logic signed [WORD_W-1:0] acc;
    } t_mac_sts;

    // position table; ok low means the pattern is not in it
    function automatic logic [8:0] decode_pos(input logic [7:0] pat);
        logic [8:0] r;
        begin
            case (pat)
                8'h18:   r = {1'b1, 8'sd0};
                8'h10:   r = {1'b1, -8'sd8};
                8'h08:   r = {1'b1, 8'sd8};
                8'h20:   r = {1'b1, -8'sd17};
                8'h04:   r = {1'b1, 8'sd17};
                8'h60:   r = {1'b1, -8'sd19};
                8'h06:   r = {1'b1, 8'sd19};
                8'h40:   r = {1'b1, -8'sd23};
                8'h02:   r = {1'b1, 8'sd23};
                8'h80:   r = {1'b1, -8'sd42};
                8'h01:   r = {1'b1, 8'sd42};
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

[hw/rtl/lfsw_mac.sv]
`default_nettype none
module lfsw_mac (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  lfsw_pkg::t_mac_req i_req,
    output lfsw_pkg::t_mac_sts o_sts
);
    import lfsw_pkg::*;

    logic [2:0]               r_cnt;
    logic signed [WORD_W-1:0] r_x;
    logic [GAIN_W-1:0]        r_g;
    logic signed [WORD_W-1:0] r_acc;

    // one gain bit per cycle, product wraps at the word width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_acc <= '0;
        end else if (i_req.start) begin
            r_cnt <= MAC_STEPS;
            r_x   <= i_req.x;
            r_g   <= i_req.gain;
            if (i_req.clr) begin
                r_acc <= '0;
            end
        end else if (r_cnt != 3'd0) begin
            if (r_g[0]) begin
                r_acc <= r_acc + r_x;
            end
            r_x   <= r_x <<< 1;
            r_g   <= r_g >> 1;
            r_cnt <= r_cnt - 3'd1;
        end
    end

    assign o_sts.busy = (r_cnt != 3'd0);
    assign o_sts.acc  = r_acc;

endmodule
`default_nettype wire

[hw/rtl/line_follow_steer_and_wheel_pid_core.sv]
`default_nettype none
// Line-follow steering and wheel PID core. One input word is one control tick: sensor
// pattern and the encoder pulses of each wheel; one output word follows per tick with
// servo duty, both wheel drives, measured speeds and finish stage. Every product term
// runs through one shared bit-serial multiply-accumulate unit: a load, one shift step
// per gain bit and a completion check. Each tick runs the three steering terms, and
// every SPEED_PERIOD-th tick runs both wheel PIDs as well, three terms each. The next
// word is taken once the current one is finished; a finished result waits in the
// output register, and the following tick stalls at its end only while that word is
// still unaccepted.
module line_follow_steer_and_wheel_pid_core #(
    parameter int SPEED_PERIOD = 5,
    parameter int TICK_MS      = 10
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [6:0]  i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // sensor_pattern[7:0], left_pulses[14:8], right_pulses[21:15], zero pad
    input  wire  [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // servo_duty[4:0], left_drive[13:5], right_drive[22:14], left_speed[30:23],
    // right_speed[38:31], stage[41:39], zero pad
    output logic [47:0] m_axis_tdata
);
    import lfsw_pkg::*;

    t_state r_state, n_state;
    t_mac_req mac_req;
    t_mac_sts mac_sts;

    logic [6:0] r_skp, r_ski, r_skd, r_wkp, r_wki, r_wkd;
    logic [5:0] r_cruise, r_finish;

    logic signed [7:0]  r_held;
    logic signed [15:0] r_integ, r_prev, r_err, r_diff;
    logic signed [15:0] r_e0 [2];
    logic signed [15:0] r_e1 [2];
    logic signed [15:0] r_e2 [2];
    logic signed [15:0] r_drive [2];
    logic signed [7:0]  r_pacc [2];
    logic signed [7:0]  r_meas [2];
    logic [2:0]  r_div;
    logic [5:0]  r_base;
    logic [2:0]  r_stage;
    logic        r_end, r_stop;
    logic [15:0] r_el, r_start;
    logic signed [3:0] r_corr;
    logic [1:0]  r_term;
    logic        r_wheel, r_wphase, r_spd;
    logic        r_ovalid;
    logic [47:0] r_odata;

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    // tick front end
    logic [7:0] pat;
    logic signed [6:0] lp, rp;
    logic [8:0] dec;
    logic prev_forced, is_end;
    logic signed [7:0] pos, pos_eff;
    logic [15:0] n_el, dt;
    logic [2:0] n_stage;
    logic [15:0] n_start;
    logic n_end, n_stop, clr_wheels;
    logic signed [15:0] n_err;
    logic [2:0] n_div;
    logic spd_tick;
    logic signed [7:0] n_pacc_l, n_pacc_r;

    always_comb begin
        pat = s_axis_tdata[7:0];
        lp  = s_axis_tdata[14:8];
        rp  = s_axis_tdata[21:15];
        dec = decode_pos(pat);
        prev_forced = (r_stage == STAGE_COAST) && (r_start != r_el);
        n_pacc_l = r_pacc[0] + 8'(lp);
        n_pacc_r = r_pacc[1] + 8'(rp);
        n_el = r_el + 16'(TICK_MS);
        is_end = (pat == 8'hFF) || (pat == 8'h7F) || (pat == 8'hFE) || (pat == 8'h7E);
        n_end = r_end;
        n_stop = r_stop;
        if (is_end) begin
            n_end = 1'b1;
            n_stop = 1'b1;
            pos = prev_forced ? 8'sd0 : r_held;
        end else if (dec[8]) begin
            pos = dec[7:0];
        end else begin
            pos = r_held;
        end
        dt = n_el - r_start;
        n_stage = r_stage;
        n_start = r_start;
        clr_wheels = 1'b0;
        pos_eff = pos;
        case (r_stage)
            STAGE_RUN: begin
                if (n_end) begin
                    n_stage = STAGE_COAST;
                    n_start = n_el;
                end
            end
            STAGE_COAST: begin
                if (dt > COAST_MS) begin
                    n_stage = STAGE_HALT;
                    n_stop = 1'b0;
                    n_start = n_el;
                    clr_wheels = 1'b1;
                end else begin
                    pos_eff = 8'sd0;
                end
            end
            STAGE_HALT: begin
                if (dt > HALT_MS) begin
                    n_stage = STAGE_SETTLE;
                    n_start = n_el;
                end else begin
                    n_stop = 1'b0;
                end
            end
            STAGE_SETTLE: begin
                if (dt > SETTLE_MS) begin
                    n_stage = STAGE_DONE;
                    n_start = n_el;
                end
            end
            default: ;
        endcase
        n_err = -16'(pos_eff);
        n_div = r_div + 3'd1;
        spd_tick = (n_div == 3'(SPEED_PERIOD));
    end

    // steering correction from the serial sum
    logic signed [15:0] sum;
    logic [16:0] mag;
    logic [13:0] q;
    logic [12:0] s3;
    logic signed [3:0] n_corr;
    always_comb begin
        sum = mac_sts.acc;
        mag = 17'd0 - {sum[15], sum};
        q = 14'((mag + 17'd7) >> 3);
        s3 = sum[15:3];
        if (sum[15]) begin
            n_corr = (q > 14'd6) ? -4'sd6 : -(4'(q));
        end else if (s3 == 13'd0) begin
            n_corr = 4'sd0;
        end else if (s3 == 13'd1) begin
            n_corr = 4'sd1;
        end else if (s3 == 13'd2) begin
            n_corr = 4'sd3;
        end else if (s3 == 13'd3) begin
            n_corr = 4'sd5;
        end else begin
            n_corr = 4'sd6;
        end
    end

    // wheel setpoint and new error
    logic signed [7:0] c8, half, set0, set1, wset;
    logic signed [7:0] nc;
    logic signed [15:0] e_new;
    always_comb begin
        c8 = {{4{r_corr[3]}}, r_corr};
        nc = -c8;
        half = (r_corr > 4'sd0) ? (c8 >>> 1) : -((nc + 8'sd1) >>> 1);
        set0 = (r_corr > 4'sd0) ? ($signed({2'b00, r_base}) - half) : $signed({2'b00, r_base});
        set1 = (r_corr > 4'sd0) ? $signed({2'b00, r_base}) : ($signed({2'b00, r_base}) + half);
        wset = r_wheel ? set1 : set0;
        if (wset < 8'sd0) begin
            wset = 8'sd0;
        end
        e_new = 16'(wset) - 16'(r_meas[r_wheel]);
    end

    // operand select for the shared unit
    logic signed [15:0] we0, we1, we2, mac_x;
    logic [6:0] mac_g;
    always_comb begin
        we0 = r_e0[r_wheel];
        we1 = r_e1[r_wheel];
        we2 = r_e2[r_wheel];
        case (r_term)
            TERM_P: begin
                mac_x = r_wphase ? (we0 - we1) : r_err;
                mac_g = r_wphase ? r_wkp : r_skp;
            end
            TERM_I: begin
                mac_x = r_wphase ? we0 : r_integ;
                mac_g = r_wphase ? r_wki : r_ski;
            end
            default: begin
                mac_x = r_wphase ? (we0 - (we1 <<< 1) + we2) : r_diff;
                mac_g = r_wphase ? r_wkd : r_skd;
            end
        endcase
    end

    logic signed [15:0] dsum, dsat;
    always_comb begin
        dsum = r_drive[r_wheel] + mac_sts.acc;
        if (dsum > DRIVE_MAX) begin
            dsat = DRIVE_MAX;
        end else if (dsum < -DRIVE_MAX) begin
            dsat = -DRIVE_MAX;
        end else begin
            dsat = dsum;
        end
    end

    logic out_free;
    assign out_free = !r_ovalid || m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:       if (in_acc) n_state = ST_MAC_GO;
            ST_MAC_GO:     n_state = ST_MAC_WAIT;
            ST_MAC_WAIT: begin
                if (!mac_sts.busy) begin
                    if (r_term != TERM_D) n_state = ST_MAC_GO;
                    else n_state = r_wphase ? ST_WHEEL_END : ST_STEER_END;
                end
            end
            ST_STEER_END:  n_state = r_spd ? ST_WHEEL_PREP : ST_DONE;
            ST_WHEEL_PREP: n_state = ST_MAC_GO;
            ST_WHEEL_END:  n_state = r_wheel ? ST_DONE : ST_WHEEL_PREP;
            ST_DONE:       if (out_free) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        mac_req.start = (r_state == ST_MAC_GO);
        mac_req.clr   = (r_term == TERM_P);
        mac_req.x     = mac_x;
        mac_req.gain  = mac_g;
    end

    lfsw_mac u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mac_req),
        .o_sts  (mac_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_skp <= 7'd1;  r_ski <= 7'd0;  r_skd <= 7'd6;
            r_wkp <= 7'd5;  r_wki <= 7'd15; r_wkd <= 7'd3;
            r_cruise <= 6'd5; r_finish <= 6'd2;
            r_held <= '0; r_integ <= '0; r_prev <= '0;
            r_err <= '0; r_diff <= '0;
            for (int k = 0; k < 2; k++) begin
                r_e0[k] <= '0; r_e1[k] <= '0; r_e2[k] <= '0;
                r_drive[k] <= '0; r_pacc[k] <= '0; r_meas[k] <= '0;
            end
            r_div <= '0; r_base <= 6'd5; r_stage <= STAGE_RUN;
            r_end <= 1'b0; r_stop <= 1'b0; r_el <= '0; r_start <= '0;
            r_corr <= '0; r_term <= TERM_P; r_wheel <= 1'b0;
            r_wphase <= 1'b0; r_spd <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_STEER_KP: r_skp <= i_cfg_data;
                    CFG_STEER_KI: r_ski <= i_cfg_data;
                    CFG_STEER_KD: r_skd <= i_cfg_data;
                    CFG_WHEEL_KP: r_wkp <= i_cfg_data;
                    CFG_WHEEL_KI: r_wki <= i_cfg_data;
                    CFG_WHEEL_KD: r_wkd <= i_cfg_data;
                    CFG_CRUISE:   r_cruise <= i_cfg_data[5:0];
                    CFG_FINISH:   r_finish <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (r_state == ST_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_el <= n_el;
                        r_held <= pos;
                        r_stage <= n_stage;
                        r_start <= n_start;
                        r_end <= n_end;
                        r_stop <= n_stop;
                        if (clr_wheels) begin
                            for (int k = 0; k < 2; k++) begin
                                r_e0[k] <= '0; r_e1[k] <= '0; r_e2[k] <= '0;
                                r_drive[k] <= '0;
                            end
                        end
                        r_err <= n_err;
                        r_integ <= r_integ + n_err;
                        r_diff <= n_err - r_prev;
                        r_prev <= n_err;
                        r_term <= TERM_P;
                        r_wphase <= 1'b0;
                        r_wheel <= 1'b0;
                        r_spd <= spd_tick;
                        if (spd_tick) begin
                            r_div <= 3'd0;
                            r_meas[0] <= n_pacc_l;
                            r_meas[1] <= n_pacc_r;
                            r_pacc[0] <= '0;
                            r_pacc[1] <= '0;
                        end else begin
                            r_div <= n_div;
                            r_pacc[0] <= n_pacc_l;
                            r_pacc[1] <= n_pacc_r;
                        end
                    end
                end
                ST_MAC_WAIT: begin
                    if (!mac_sts.busy && r_term != TERM_D) begin
                        r_term <= r_term + 2'd1;
                    end
                end
                ST_STEER_END: begin
                    r_corr <= n_corr;
                end
                ST_WHEEL_PREP: begin
                    r_wphase <= 1'b1;
                    r_term <= TERM_P;
                    r_e2[r_wheel] <= r_e1[r_wheel];
                    r_e1[r_wheel] <= r_e0[r_wheel];
                    r_e0[r_wheel] <= e_new;
                end
                ST_WHEEL_END: begin
                    r_drive[r_wheel] <= dsat;
                    if (r_wheel) begin
                        r_base <= r_stop ? 6'd0 : (r_end ? r_finish : r_cruise);
                    end else begin
                        r_wheel <= 1'b1;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_odata <= {6'd0, r_stage, r_meas[1], r_meas[0],
                                    r_drive[1][8:0], r_drive[0][8:0],
                                    DUTY_CENTRE - 5'({r_corr[3], r_corr})};
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage <= STAGE_DONE) else $error("finish stage out of range");
    a_servo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_odata[4:0] >= 5'd12 && r_odata[4:0] <= 5'd24))
        else $error("servo duty out of range");
    a_mac_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_req.start |-> !mac_sts.busy) else $error("multiply started while busy");
    a_drive_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drive[0] <= DRIVE_MAX && r_drive[0] >= -DRIVE_MAX))
        else $error("left drive not saturated");

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import lfsw_pkg::*;

    typedef struct packed {
        logic [4:0]        duty;
        logic signed [8:0] ldrv;
        logic signed [8:0] rdrv;
        logic signed [7:0] lspd;
        logic signed [7:0] rspd;
        logic [2:0]        stage;
    } t_ctrl_out;

    typedef struct {
        logic [7:0]        pat;
        logic signed [6:0] lp;
        logic signed [6:0] rp;
        bit                typed;
        t_ctrl_out         res;
    } t_tick_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [6:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tready = 1'b0;
    wire         o_cfg_ready;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [47:0] m_axis_tdata;

    line_follow_steer_and_wheel_pid_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // model of the controller
    int unsigned gain [8];
    int          held_pos, s_integ, s_prev;
    int          w_err [6];
    int          w_drv [2];
    int          pacc [2];
    int          mspd [2];
    int unsigned divider;
    int          base_spd;
    logic [2:0]  seq_stage;
    bit          end_seen, stop_req;
    logic [15:0] elapsed, stage_t0;

    t_ctrl_out   expected_ctrl [$];
    int          errors = 0;
    bit          burst = 1'b0;
    bit          allow_end = 1'b0;

    function automatic int w16(int v);
        return int'(shortint'(v));
    endfunction

    function automatic int wheel_update(int k, int setp, int spd);
        int d, inc, o;
        w_err[k*3+2] = w_err[k*3+1];
        w_err[k*3+1] = w_err[k*3];
        w_err[k*3]   = w16(setp - spd);
        d   = w16(w_err[k*3] - 2 * w_err[k*3+1] + w_err[k*3+2]);
        inc = w16(int'(gain[CFG_WHEEL_KP]) * w16(w_err[k*3] - w_err[k*3+1])
                  + int'(gain[CFG_WHEEL_KI]) * w_err[k*3]
                  + int'(gain[CFG_WHEEL_KD]) * d);
        o = w16(w_drv[k] + inc);
        if (o > 255) o = 255;
        if (o < -255) o = -255;
        return o;
    endfunction

    function automatic t_ctrl_out predict_tick(logic [7:0] pat, logic signed [6:0] lp,
                                               logic signed [6:0] rp);
        int pos, err, sum, corr, lset, rset;
        bit prev_forced;
        logic [15:0] dt;
        t_ctrl_out r;
        prev_forced = (seq_stage == STAGE_COAST) && (stage_t0 != elapsed);
        pacc[0] = int'(byte'(pacc[0] + int'(lp)));
        pacc[1] = int'(byte'(pacc[1] + int'(rp)));
        elapsed = elapsed + 16'd10;
        pos = held_pos;
        case (pat)
            8'hFF, 8'h7F, 8'hFE, 8'h7E: begin
                end_seen = 1'b1;
                stop_req = 1'b1;
                pos = prev_forced ? 0 : held_pos;
            end
            8'h18: pos = 0;
            8'h10: pos = -8;
            8'h08: pos = 8;
            8'h20: pos = -17;
            8'h04: pos = 17;
            8'h60: pos = -19;
            8'h06: pos = 19;
            8'h40: pos = -23;
            8'h02: pos = 23;
            8'h80: pos = -42;
            8'h01: pos = 42;
            default: ;
        endcase
        held_pos = pos;
        dt = elapsed - stage_t0;
        case (seq_stage)
            STAGE_RUN: if (end_seen) begin
                seq_stage = STAGE_COAST;
                stage_t0 = elapsed;
            end
            STAGE_COAST: if (dt > COAST_MS) begin
                seq_stage = STAGE_HALT;
                stop_req = 1'b0;
                stage_t0 = elapsed;
                foreach (w_err[i]) w_err[i] = 0;
                w_drv[0] = 0;
                w_drv[1] = 0;
            end else begin
                pos = 0;
            end
            STAGE_HALT: if (dt > HALT_MS) begin
                seq_stage = STAGE_SETTLE;
                stage_t0 = elapsed;
            end else begin
                stop_req = 1'b0;
            end
            STAGE_SETTLE: if (dt > SETTLE_MS) begin
                seq_stage = STAGE_DONE;
                stage_t0 = elapsed;
            end
            default: ;
        endcase
        err = -pos;
        s_integ = w16(s_integ + err);
        sum = w16(int'(gain[CFG_STEER_KP]) * err + int'(gain[CFG_STEER_KI]) * s_integ
                  + int'(gain[CFG_STEER_KD]) * w16(err - s_prev));
        s_prev = err;
        corr = sum >>> 3;
        if (corr < -6) corr = -6;
        if (corr > 0) corr = (corr * 5) / 3;
        if (corr > 6) corr = 6;
        divider = (divider + 1) & 7;
        if (divider == 5) begin
            divider = 0;
            mspd = pacc;
            pacc[0] = 0;
            pacc[1] = 0;
            if (corr > 0) begin
                lset = base_spd - (corr >>> 1);
                rset = base_spd;
            end else begin
                lset = base_spd;
                rset = base_spd + (corr >>> 1);
            end
            if (lset < 0) lset = 0;
            if (rset < 0) rset = 0;
            w_drv[0] = wheel_update(0, lset, mspd[0]);
            w_drv[1] = wheel_update(1, rset, mspd[1]);
            if (stop_req) base_spd = 0;
            else base_spd = end_seen ? int'(gain[CFG_FINISH]) : int'(gain[CFG_CRUISE]);
        end
        r.duty  = 5'(18 - corr);
        r.ldrv  = 9'(w_drv[0]);
        r.rdrv  = 9'(w_drv[1]);
        r.lspd  = 8'(mspd[0]);
        r.rspd  = 8'(mspd[1]);
        r.stage = seq_stage;
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [6:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        gain[idx] = (idx == CFG_CRUISE || idx == CFG_FINISH) ? val & 7'h3F : val;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        wait (expected_ctrl.size() == 0);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic send_tick(logic [7:0] pat, logic signed [6:0] lp, logic signed [6:0] rp,
                             bit typed, t_ctrl_out typed_res);
        t_ctrl_out p;
        int gap;
        gap = burst ? 0 : $urandom_range(7);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {2'b00, rp, lp, pat};
        do @(posedge i_clk); while (!s_axis_tready);
        p = predict_tick(pat, lp, rp);
        expected_ctrl.push_back(typed ? typed_res : p);
    endtask

    task automatic random_ticks(int n);
        logic [7:0] pat;
        int sel;
        logic [7:0] known [11] = '{8'h18, 8'h10, 8'h08, 8'h20, 8'h04, 8'h60, 8'h06,
                                   8'h40, 8'h02, 8'h80, 8'h01};
        logic [7:0] ends [4] = '{8'hFF, 8'h7F, 8'hFE, 8'h7E};
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) burst = ($urandom_range(3) == 0);
            sel = $urandom_range(99);
            if (sel < 65) pat = known[$urandom_range(10)];
            else if (sel < 75 && allow_end) pat = ends[$urandom_range(3)];
            else begin
                pat = 8'($urandom);
                // keep the end mark out until the finish phase
                while (!allow_end && (pat == 8'hFF || pat == 8'h7F || pat == 8'hFE
                                      || pat == 8'h7E))
                    pat = 8'($urandom);
            end
            send_tick(pat, 7'($urandom), 7'($urandom), 1'b0, '0);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // drain and check results
    initial begin
        t_ctrl_out got, want;
        int stall;
        forever begin
            stall = burst ? 0 : $urandom_range(7);
            @(negedge i_clk);
            m_axis_tready = 1'b0;
            repeat (stall) @(negedge i_clk);
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.duty  = m_axis_tdata[4:0];
            got.ldrv  = m_axis_tdata[13:5];
            got.rdrv  = m_axis_tdata[22:14];
            got.lspd  = m_axis_tdata[30:23];
            got.rspd  = m_axis_tdata[38:31];
            got.stage = m_axis_tdata[41:39];
            if (expected_ctrl.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h", got);
            end else begin
                want = expected_ctrl.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch (exp/got): duty %0d/%0d ldrv %0d/%0d rdrv %0d/%0d",
                                 want.duty, got.duty, want.ldrv, got.ldrv,
                                 want.rdrv, got.rdrv);
                        $display("    lspd %0d/%0d rspd %0d/%0d stage %0d/%0d",
                                 want.lspd, got.lspd, want.rspd, got.rspd,
                                 want.stage, got.stage);
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_tick_row dir [$];
        gain = '{1, 0, 6, 5, 15, 3, 5, 2};
        held_pos = 0; s_integ = 0; s_prev = 0;
        w_err = '{default: 0}; w_drv = '{0, 0}; pacc = '{0, 0}; mspd = '{0, 0};
        divider = 0; base_spd = 5; seq_stage = STAGE_RUN;
        end_seen = 0; stop_req = 0; elapsed = 0; stage_t0 = 0;

        // centred line from reset: no steering, no drive yet
        dir.push_back('{8'h18, 7'sd0, 7'sd0, 1'b1, '{5'd18, 9'sd0, 9'sd0, 8'sd0, 8'sd0,
                                                  STAGE_RUN}});
        dir.push_back('{8'h10, 7'sd63, -7'sd64, 1'b0, '0});
        dir.push_back('{8'h08, 7'sd63, -7'sd64, 1'b0, '0});
        dir.push_back('{8'h20, 7'sd63, -7'sd64, 1'b0, '0});
        dir.push_back('{8'h04, 7'sd63, -7'sd64, 1'b0, '0});
        dir.push_back('{8'h60, -7'sd64, 7'sd63, 1'b0, '0});
        dir.push_back('{8'h06, -7'sd64, 7'sd63, 1'b0, '0});
        dir.push_back('{8'h40, -7'sd64, 7'sd63, 1'b0, '0});
        dir.push_back('{8'h02, -7'sd64, 7'sd63, 1'b0, '0});
        dir.push_back('{8'h80, -7'sd1, 7'sd1, 1'b0, '0});
        dir.push_back('{8'h00, -7'sd1, 7'sd1, 1'b0, '0});
        dir.push_back('{8'h01, 7'sd0, 7'sd0, 1'b0, '0});
        dir.push_back('{8'h55, 7'sd0, 7'sd0, 1'b0, '0});
        dir.push_back('{8'hAA, 7'sd63, 7'sd63, 1'b0, '0});
        dir.push_back('{8'h80, -7'sd64, -7'sd64, 1'b0, '0});
        dir.push_back('{8'h18, 7'sd63, 7'sd63, 1'b0, '0});

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        burst = 1'b1;
        foreach (dir[i]) send_tick(dir[i].pat, dir[i].lp, dir[i].rp, dir[i].typed, dir[i].res);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        random_ticks(15);

        // all gains and speeds at zero
        wait_idle();
        for (int r = CFG_STEER_KP; r <= CFG_FINISH; r++) write_reg(3'(r), 7'd0);
        random_ticks(15);

        // all at full scale
        wait_idle();
        for (int r = CFG_STEER_KP; r <= CFG_FINISH; r++) write_reg(3'(r), 7'h7F);
        random_ticks(15);

        wait_idle();
        for (int r = CFG_STEER_KP; r <= CFG_FINISH; r++) write_reg(3'(r), 7'($urandom));
        random_ticks(15);

        // finish run: end mark, then long enough to reach the settle stage
        wait_idle();
        for (int r = CFG_STEER_KP; r <= CFG_FINISH; r++)
            write_reg(3'(r), 7'($urandom_range(24)));
        allow_end = 1'b1;
        send_tick(8'h40, 7'sd5, 7'sd5, 1'b0, '0);
        send_tick(8'hFF, 7'sd5, 7'sd5, 1'b0, '0);
        send_tick(8'h7F, 7'sd5, 7'sd5, 1'b0, '0);
        send_tick(8'hFE, 7'sd5, 7'sd5, 1'b0, '0);
        send_tick(8'h7E, 7'sd5, 7'sd5, 1'b0, '0);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        random_ticks(300);
        wait_idle();
        write_reg(CFG_FINISH, 7'h3F);
        write_reg(CFG_STEER_KI, 7'($urandom));
        random_ticks(285);

        wait_idle();
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
hw/rtl/lfsw_pkg.sv
hw/rtl/lfsw_mac.sv
hw/rtl/line_follow_steer_and_wheel_pid_core.sv
tb/sv/tb_top.sv
